@@ rtl/vsr_pkg.sv @@
`timescale 1ns / 1ps
package vsr_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_W = 6;
  localparam int ID_W = 12;
  localparam int IWW = ID_W - BIT_W;
  localparam int POS_W = 14;
  localparam int LEFT_W = 13;
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int DEFAULT_TABLE_DEPTH = 4096;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_NEXT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_ID       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXCLUDE_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT = 3'd7;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } find_res_t;

  typedef struct packed {
    logic [BIT_W-1:0] pos_bit;
    logic [BIT_W-1:0] end_bit;
    logic             end_same;
    logic             down;
  } find_req_t;

endpackage

@@ rtl/vsr_map_mem.sv @@
`timescale 1ns / 1ps
module vsr_map_mem #(
  parameter int TableDepth = vsr_pkg::DEFAULT_TABLE_DEPTH,
  parameter int NumWords = (TableDepth + vsr_pkg::WORD_BITS - 1) / vsr_pkg::WORD_BITS,
  parameter int AddrW = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [vsr_pkg::WORD_BITS-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [vsr_pkg::WORD_BITS-1:0] rdata_o
);
  import vsr_pkg::*;

  logic [WORD_BITS-1:0] mem [NumWords];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/vsr_word_find.sv @@
`timescale 1ns / 1ps
module vsr_word_find (
  input  logic [vsr_pkg::WORD_BITS-1:0] word_i,
  input  vsr_pkg::find_req_t            req_i,
  output vsr_pkg::find_res_t            res_o
);
  import vsr_pkg::*;

  logic [WORD_BITS-1:0] near_mask;
  logic [WORD_BITS-1:0] far_mask;
  logic [WORD_BITS-1:0] masked;
  logic [BIT_W:0]       end_plus;

  assign end_plus = {1'b0, req_i.end_bit} + 7'd1;

  always_comb begin
    if (req_i.down) begin
      near_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - req_i.pos_bit);
      far_mask  = req_i.end_same ? ({WORD_BITS{1'b1}} << end_plus) : {WORD_BITS{1'b1}};
    end else begin
      near_mask = {WORD_BITS{1'b1}} << req_i.pos_bit;
      far_mask  = req_i.end_same ? ((WORD_BITS'(1) << req_i.end_bit) - WORD_BITS'(1))
                                 : {WORD_BITS{1'b1}};
    end
    masked = word_i & near_mask & far_mask;
  end

  // lowest set bit going up, highest going down
  always_comb begin
    res_o.hit = |masked;
    res_o.bit_idx = '0;
    if (req_i.down) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (masked[i]) res_o.bit_idx = BIT_W'(i);
      end
    end else begin
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
        if (masked[i]) res_o.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

@@ rtl/valid_id_range_scanner.sv @@
`timescale 1ns / 1ps
// valid id range scanner
// input items on s_axis: tuser holds the command (write mark, open scan,
// fetch next id), tdata holds entry_id and entry_valid for writes.
// result items on m_axis, one per fetch: tuser holds found, tdata key_id.
// the valid map lives in one memory of 64-bit words with a registered read.
// a write reads the word and writes it back. an open sets up the range and,
// with a skip count, visits map words and steps past the valid ids skipped.
// a fetch visits map words until it finds a valid id or reaches the range end;
// a fetch with no results left answers without reading the map.
// each visit is paced by the single read port of the map memory.
// after reset the map is cleared by a pass of one word per cycle
// (TABLE_DEPTH/64 words rounded up, 64 words by default); s_axis_tready stays low
// during the pass, configuration writes are taken at any time.
// results sit in an output register; while m_axis stalls the block still
// takes the next item and holds a further result until the register frees.
module valid_id_range_scanner #(
  parameter int TABLE_DEPTH = vsr_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // entry_id, entry_valid
  input  logic [1:0]                      s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // key_id
  output logic [0:0]                      m_axis_tuser,  // found
  input  logic                            cfg_we_i,
  input  logic [vsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vsr_pkg::CFG_W-1:0]       cfg_data_i
);
  import vsr_pkg::*;

  localparam int NumWords = (TABLE_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int XW = (AddrW > IWW) ? AddrW : IWW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WR_WB = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [12:0] rmin_q;
  logic [12:0] rmax_q;
  logic [ID_W-1:0] top_q;
  logic exmin_q, exmax_q, desc_q;
  logic [12:0] skip_cfg_q;
  logic [13:0] limit_q;

  logic signed [POS_W-1:0] pos_q, pos_d;
  logic signed [POS_W-1:0] end_q, end_d;
  logic down_q, down_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic no_limit_q, no_limit_d;
  logic [12:0] skip_q, skip_d;
  logic skipping_q, skipping_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic oor_q, oor_d;

  logic [ID_W-1:0] wr_id_q, wr_id_d;
  logic wr_val_q, wr_val_d;

  logic out_valid_q, out_valid_d;
  logic out_found_q;
  logic [ID_W-1:0] out_key_q;
  logic out_load, out_found_d;
  logic [ID_W-1:0] out_key_d;
  logic out_free;

  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata, eff_word, bit_sel;

  find_req_t find_req;
  find_res_t find_res;

  logic in_fire;
  logic [1:0] in_cmd;
  logic [ID_W-1:0] in_id;
  logic in_val;

  logic signed [POS_W-1:0] lo, hi, id_hit, step_pos, adv_pos;
  logic [IWW-1:0] pos_widx;
  logic end_same;

  function automatic logic [AddrW-1:0] widx_addr(input logic [IWW-1:0] w);
    logic [XW-1:0] wx;
    wx = XW'(w);
    return wx[AddrW-1:0];
  endfunction

  assign in_cmd = s_axis_tuser;
  assign in_id  = s_axis_tdata[ID_W-1:0];
  assign in_val = s_axis_tdata[ID_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = {{(16 - ID_W){1'b0}}, out_key_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmin_q     <= 13'h1FFF;
      rmax_q     <= 13'h1FFF;
      top_q      <= 12'hFFF;
      exmin_q    <= 1'b0;
      exmax_q    <= 1'b0;
      desc_q     <= 1'b0;
      skip_cfg_q <= '0;
      limit_q    <= 14'h3FFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RANGE_MIN:    rmin_q     <= cfg_data_i[12:0];
        REG_RANGE_MAX:    rmax_q     <= cfg_data_i[12:0];
        REG_TOP_ID:       top_q      <= cfg_data_i[ID_W-1:0];
        REG_EXCLUDE_MIN:  exmin_q    <= cfg_data_i[0];
        REG_EXCLUDE_MAX:  exmax_q    <= cfg_data_i[0];
        REG_DESCENDING:   desc_q     <= cfg_data_i[0];
        REG_SKIP_COUNT:   skip_cfg_q <= cfg_data_i[12:0];
        REG_RESULT_LIMIT: limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // trimmed bounds for open
  always_comb begin
    if (rmin_q[12]) lo = '0;
    else lo = POS_W'(rmin_q) + POS_W'(exmin_q);
    if (rmax_q[12] || (rmax_q[11:0] > top_q)) hi = POS_W'(top_q);
    else hi = POS_W'(rmax_q) - POS_W'(exmax_q);
  end

  vsr_map_mem #(
    .TableDepth(TABLE_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign eff_word = oor_q ? '0 : mem_rdata;
  assign pos_widx = pos_q[ID_W-1:BIT_W];
  assign end_same = (end_q[POS_W-1:BIT_W] == pos_q[POS_W-1:BIT_W]);

  assign find_req.pos_bit  = pos_q[BIT_W-1:0];
  assign find_req.end_bit  = end_q[BIT_W-1:0];
  assign find_req.end_same = end_same;
  assign find_req.down     = down_q;

  vsr_word_find u_find (
    .word_i (eff_word),
    .req_i  (find_req),
    .res_o  (find_res)
  );

  assign id_hit = {pos_q[POS_W-1:BIT_W], find_res.bit_idx};
  assign step_pos = down_q ? (id_hit - POS_W'(1)) : (id_hit + POS_W'(1));
  always_comb begin
    if (end_same) adv_pos = end_q;
    else if (down_q) adv_pos = {pos_q[POS_W-1:BIT_W], {BIT_W{1'b0}}} - POS_W'(1);
    else adv_pos = {pos_q[POS_W-1:BIT_W] + (POS_W - BIT_W)'(1), {BIT_W{1'b0}}};
  end

  assign bit_sel = WORD_BITS'(1) << wr_id_q[BIT_W-1:0];

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    end_d      = end_q;
    down_d     = down_q;
    left_d     = left_q;
    no_limit_d = no_limit_q;
    skip_d     = skip_q;
    skipping_d = skipping_q;
    clr_d      = clr_q;
    oor_d      = oor_q;
    wr_id_d    = wr_id_q;
    wr_val_d   = wr_val_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = widx_addr(pos_widx);
    out_load   = 1'b0;
    out_found_d = 1'b0;
    out_key_d  = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d = clr_q + AddrW'(1);
        if (32'(clr_q) == NumWords - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_WRITE: begin
              if (32'(in_id) < TABLE_DEPTH) begin
                mem_re = 1'b1;
                mem_raddr = widx_addr(in_id[ID_W-1:BIT_W]);
                oor_d = 1'b0;
                wr_id_d = in_id;
                wr_val_d = in_val;
                state_d = S_WR_WB;
              end
            end
            CMD_OPEN: begin
              down_d = desc_q;
              if (desc_q) begin
                pos_d = hi;
                end_d = lo - POS_W'(1);
              end else begin
                pos_d = lo;
                end_d = hi + POS_W'(1);
              end
              if (lo > hi) pos_d = end_d;
              no_limit_d = limit_q[13];
              left_d = limit_q[13] ? '0 : limit_q[LEFT_W-1:0];
              skip_d = skip_cfg_q;
              skipping_d = 1'b1;
              if (skip_cfg_q != '0) state_d = S_RD;
            end
            CMD_NEXT: begin
              skipping_d = 1'b0;
              if (!no_limit_q && left_q == '0) state_d = S_MISS;
              else state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_WR_WB: begin
        mem_we = 1'b1;
        mem_waddr = widx_addr(wr_id_q[ID_W-1:BIT_W]);
        mem_wdata = wr_val_q ? (mem_rdata | bit_sel) : (mem_rdata & ~bit_sel);
        state_d = S_IDLE;
      end
      S_RD: begin
        if (pos_q == end_q) begin
          state_d = skipping_q ? S_IDLE : S_MISS;
        end else begin
          mem_re = 1'b1;
          oor_d = !(32'(pos_widx) < NumWords);
          state_d = S_EV;
        end
      end
      S_EV: begin
        if (!find_res.hit) begin
          pos_d = adv_pos;
          state_d = S_RD;
        end else if (skipping_q) begin
          pos_d = step_pos;
          skip_d = skip_q - 13'd1;
          state_d = (skip_q == 13'd1) ? S_IDLE : S_RD;
        end else if (out_free) begin
          pos_d = step_pos;
          if (!no_limit_q) left_d = left_q - LEFT_W'(1);
          out_load = 1'b1;
          out_found_d = 1'b1;
          out_key_d = id_hit[ID_W-1:0];
          state_d = S_IDLE;
        end
      end
      S_MISS: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pos_q       <= '0;
      end_q       <= '0;
      down_q      <= 1'b0;
      left_q      <= '0;
      no_limit_q  <= 1'b0;
      skip_q      <= '0;
      skipping_q  <= 1'b0;
      clr_q       <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      down_q      <= down_d;
      left_q      <= left_d;
      no_limit_q  <= no_limit_d;
      skip_q      <= skip_d;
      skipping_q  <= skipping_d;
      clr_q       <= clr_d;
      oor_q       <= oor_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_id_q  <= wr_id_d;
    wr_val_q <= wr_val_d;
    if (out_load) begin
      out_found_q <= out_found_d;
      out_key_q   <= out_key_d;
    end
  end

endmodule
